// ===== hdl/file_inode_table_allocator_assert.svh =====
// Assertion macros for the inode table allocator top level.
`ifndef FILE_INODE_TABLE_ALLOCATOR_ASSERT_SVH
`define FILE_INODE_TABLE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define FITA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define FITA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/fita_pkg.sv =====
// Package with the types and constants of the inode table allocator.
package fita_pkg;

	// The free map is held as rows of this many block bits.
	localparam int WORD_W     = 32;
	localparam int WORD_IDX_W = 5;

	localparam logic [8:0] LAST_RES_RST = 9'd1;

	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_CREATE = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_FORMAT = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_EXISTS    = 3'd2,
		ST_FULL      = 3'd3,
		ST_NO_BLOCK  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TSCAN,
		S_MSCAN,
		S_DEL_WR,
		S_FMT,
		S_DONE
	} state_t;

	// Compare result for the table entry read in the previous cycle.
	typedef struct packed {
		logic valid;
		logic hit;
	} tbl_stat_t;

	// Lowest free block within the free map row read in the previous cycle.
	typedef struct packed {
		logic                  free_any;
		logic [WORD_IDX_W-1:0] free_bit;
	} map_stat_t;

endpackage

// ===== hdl/file_inode_table_allocator.sv =====
// Top level: sequencer of the inode table allocator, scanning table and free map.
// Lookup: every table entry is read, then the result strobe rises; delete adds the S_DEL_WR state on a hit.
// Create: the table scan, then the free map search, which reads one row a cycle.
// Format: one free map row written per cycle.
// One item at a time; busy falls the cycle after the strobe. The table scan reads one entry a cycle.
// Reset clears the valid bits and the free map row marks at once; no clearing pass is needed.
`include "file_inode_table_allocator_assert.svh"

module file_inode_table_allocator import fita_pkg::*; #(
	parameter int MAX_FILES   = 16,
	parameter int BLOCK_COUNT = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic signed [31:0] file_id,
	output logic               done,
	output logic [2:0]         status,
	output logic [8:0]         block_number,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [8:0]         cfg_data
);

	localparam int IW   = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
	localparam int FCW  = $clog2(MAX_FILES + 1);
	localparam int BW   = $clog2(BLOCK_COUNT);
	localparam int ROWS = (BLOCK_COUNT + WORD_W - 1) / WORD_W;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int RCW  = $clog2(ROWS + 1);

	state_t            state_q, state_d;
	action_t           act_q;
	logic [31:0]       id_q;
	logic [8:0]        last_res_q;
	logic [FCW-1:0]    rd_cnt_q;
	logic              chk_vld_s1;
	logic [IW-1:0]     chk_idx_s1;
	logic              hit_q;
	logic [IW-1:0]     hit_idx_q;
	logic [BW-1:0]     hit_blk_q;
	logic              slot_ok_q;
	logic [IW-1:0]     slot_idx_q;
	logic [RCW-1:0]    row_cnt_q;
	logic              rchk_vld_s1;
	logic [RW-1:0]     rchk_row_s1;
	status_t           status_q;
	logic [BW-1:0]     blk_q;
	logic [FCW-1:0]    live_q;

	tbl_stat_t         tbl_stat;
	logic [BW-1:0]     tbl_rd_blk;
	map_stat_t         map_stat;
	logic [WORD_W-1:0] map_word;

	logic              tbl_rd_en, tbl_wr_en, tbl_clr_en;
	logic              map_rd_en, map_wr_en;
	logic [RW-1:0]     map_rd_row, map_wr_row;
	logic [WORD_W-1:0] map_wr_data;
	logic              res_ld;
	status_t           res_status;
	logic [BW-1:0]     res_blk;
	logic              live_inc, live_dec;
	logic              accept, tscan_end, mscan_end;
	logic [31:0]       hit_blk32, found_blk32, blk_out32;
	logic [15:0]       row16, lr_row16;
	logic [WORD_IDX_W-1:0] lr_lo;
	logic [WORD_W-1:0] fmt_word;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign done      = (state_q == S_DONE);
	assign cfg_ready = !busy;
	assign status    = status_q;
	assign blk_out32 = 32'(blk_q);
	assign block_number = blk_out32[8:0];

	assign tscan_end   = (rd_cnt_q == FCW'(MAX_FILES)) && !chk_vld_s1;
	assign mscan_end   = (row_cnt_q == RCW'(ROWS)) && !rchk_vld_s1;
	assign hit_blk32   = 32'(hit_blk_q);
	assign found_blk32 = (32'(rchk_row_s1) << WORD_IDX_W) | 32'(map_stat.free_bit);

	// Format pattern for the current row: blocks up to the reserved bound are used.
	assign row16    = 16'(row_cnt_q);
	assign lr_row16 = 16'(last_res_q >> WORD_IDX_W);
	assign lr_lo    = last_res_q[WORD_IDX_W-1:0];
	always_comb begin
		if (row16 < lr_row16) begin
			fmt_word = '1;
		end else if (row16 == lr_row16) begin
			fmt_word = ~({WORD_W{1'b1}} << 1 << lr_lo);
		end else begin
			fmt_word = '0;
		end
	end

	fita_inode_tbl #(
		.MAX_FILES (MAX_FILES),
		.BW        (BW),
		.IW        (IW)
	) u_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (tbl_rd_en),
		.rd_idx  (rd_cnt_q[IW-1:0]),
		.key     (id_q),
		.wr_en   (tbl_wr_en),
		.wr_idx  (slot_idx_q),
		.wr_id   (id_q),
		.wr_blk  (found_blk32[BW-1:0]),
		.clr_en  (tbl_clr_en),
		.clr_idx (hit_idx_q),
		.stat    (tbl_stat),
		.rd_blk  (tbl_rd_blk)
	);

	fita_free_map #(
		.BLOCK_COUNT (BLOCK_COUNT),
		.ROWS        (ROWS),
		.RW          (RW)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (map_rd_en),
		.rd_row  (map_rd_row),
		.wr_en   (map_wr_en),
		.wr_row  (map_wr_row),
		.wr_data (map_wr_data),
		.stat    (map_stat),
		.rd_word (map_word)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and the strobes that drive the table, the free map and the result.
	always_comb begin
		state_d     = state_q;
		tbl_rd_en   = 1'b0;
		tbl_wr_en   = 1'b0;
		tbl_clr_en  = 1'b0;
		map_rd_en   = 1'b0;
		map_rd_row  = row_cnt_q[RW-1:0];
		map_wr_en   = 1'b0;
		map_wr_row  = row_cnt_q[RW-1:0];
		map_wr_data = fmt_word;
		res_ld      = 1'b0;
		res_status  = ST_OK;
		res_blk     = '0;
		live_inc    = 1'b0;
		live_dec    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (action_t'(action) == ACT_FORMAT) ? S_FMT : S_TSCAN;
				end
			end
			S_TSCAN: begin
				tbl_rd_en = (rd_cnt_q < FCW'(MAX_FILES));
				if (tscan_end) begin
					state_d = S_DONE;
					res_ld  = 1'b1;
					unique case (act_q)
						ACT_LOOKUP: begin
							res_status = hit_q ? ST_OK : ST_NOT_FOUND;
							res_blk    = hit_q ? hit_blk_q : '0;
						end
						ACT_DELETE: begin
							if (hit_q) begin
								// Drop the entry now, free its block after the row read.
								res_ld     = 1'b0;
								state_d    = S_DEL_WR;
								tbl_clr_en = 1'b1;
								live_dec   = (live_q != '0);
								map_rd_en  = 1'b1;
								map_rd_row = RW'(hit_blk32 >> WORD_IDX_W);
							end else begin
								res_status = ST_NOT_FOUND;
							end
						end
						ACT_CREATE: begin
							if (hit_q) begin
								res_status = ST_EXISTS;
							end else if (!slot_ok_q) begin
								res_status = ST_FULL;
							end else begin
								res_ld  = 1'b0;
								state_d = S_MSCAN;
							end
						end
						ACT_FORMAT: begin
							res_status = ST_OK;
						end
						default: begin
							res_status = ST_OK;
						end
					endcase
				end
			end
			S_MSCAN: begin
				map_rd_en = (row_cnt_q < RCW'(ROWS));
				if (rchk_vld_s1 && map_stat.free_any) begin
					// Lowest free block found: claim it and fill the slot.
					map_wr_en   = 1'b1;
					map_wr_row  = rchk_row_s1;
					map_wr_data = map_word | (WORD_W'(1) << map_stat.free_bit);
					tbl_wr_en   = 1'b1;
					live_inc    = 1'b1;
					res_ld      = 1'b1;
					res_status  = ST_OK;
					res_blk     = found_blk32[BW-1:0];
					state_d     = S_DONE;
				end else if (mscan_end) begin
					res_ld     = 1'b1;
					res_status = ST_NO_BLOCK;
					state_d    = S_DONE;
				end
			end
			S_DEL_WR: begin
				map_wr_en   = 1'b1;
				map_wr_row  = RW'(hit_blk32 >> WORD_IDX_W);
				map_wr_data = map_word & ~(WORD_W'(1) << hit_blk32[WORD_IDX_W-1:0]);
				res_ld      = 1'b1;
				res_status  = ST_OK;
				state_d     = S_DONE;
			end
			S_FMT: begin
				map_wr_en = 1'b1;
				if (row_cnt_q == RCW'(ROWS - 1)) begin
					res_ld     = 1'b1;
					res_status = ST_OK;
					state_d    = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers: scan counters, check stages, flags, live count, reserved bound.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q    <= '0;
			chk_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			slot_ok_q   <= 1'b0;
			row_cnt_q   <= '0;
			rchk_vld_s1 <= 1'b0;
			live_q      <= '0;
			last_res_q  <= LAST_RES_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				last_res_q <= cfg_data;
			end
			if (accept) begin
				rd_cnt_q    <= '0;
				chk_vld_s1  <= 1'b0;
				hit_q       <= 1'b0;
				slot_ok_q   <= 1'b0;
				row_cnt_q   <= '0;
				rchk_vld_s1 <= 1'b0;
			end else begin
				chk_vld_s1 <= tbl_rd_en;
				if (tbl_rd_en) begin
					rd_cnt_q <= rd_cnt_q + FCW'(1);
				end
				if (chk_vld_s1 && tbl_stat.hit) begin
					hit_q <= 1'b1;
				end
				if (chk_vld_s1 && !tbl_stat.valid) begin
					slot_ok_q <= 1'b1;
				end
				rchk_vld_s1 <= map_rd_en && (state_q == S_MSCAN);
				if ((map_rd_en && (state_q == S_MSCAN)) || (state_q == S_FMT)) begin
					row_cnt_q <= row_cnt_q + RCW'(1);
				end
			end
			if (live_inc) begin
				live_q <= live_q + FCW'(1);
			end else if (live_dec) begin
				live_q <= live_q - FCW'(1);
			end
		end
	end

	// Item and scan payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action_t'(action);
			id_q  <= file_id;
		end
		chk_idx_s1  <= rd_cnt_q[IW-1:0];
		rchk_row_s1 <= row_cnt_q[RW-1:0];
		if (chk_vld_s1 && tbl_stat.hit && !hit_q) begin
			hit_idx_q <= chk_idx_s1;
			hit_blk_q <= tbl_rd_blk;
		end
		if (chk_vld_s1 && !tbl_stat.valid && !slot_ok_q) begin
			slot_idx_q <= chk_idx_s1;
		end
		if (res_ld) begin
			status_q <= res_status;
			blk_q    <= res_blk;
		end
	end

	`FITA_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for more than one cycle")
	`FITA_ASSERT_NEXT(a_busy_after_start, accept, busy, "busy not raised after an accepted item")
	`FITA_ASSERT_NOW(a_live_bound, 1'b1, live_q <= FCW'(MAX_FILES), "live file count above table size")
	`FITA_ASSERT_NOW(a_err_blk_zero, done && (status != ST_OK), block_number == 9'd0, "error result with a block number")

endmodule

// ===== hdl/fita_inode_tbl.sv =====
// Inode table: id and block memory, valid bits and the shared id comparator.
module fita_inode_tbl import fita_pkg::*; #(
	parameter int MAX_FILES = 16,
	parameter int BW        = 9,
	parameter int IW        = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [IW-1:0]   rd_idx,
	input  logic [31:0]     key,
	input  logic            wr_en,
	input  logic [IW-1:0]   wr_idx,
	input  logic [31:0]     wr_id,
	input  logic [BW-1:0]   wr_blk,
	input  logic            clr_en,
	input  logic [IW-1:0]   clr_idx,
	output tbl_stat_t       stat,
	output logic [BW-1:0]   rd_blk
);

	logic [31:0]          id_mem  [MAX_FILES];
	logic [BW-1:0]        blk_mem [MAX_FILES];
	logic [MAX_FILES-1:0] vld_q;
	logic [31:0]          rd_id_q;
	logic [BW-1:0]        rd_blk_q;
	logic                 rd_vld_q;

	// Entry memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_mem[wr_idx]  <= wr_id;
			blk_mem[wr_idx] <= wr_blk;
		end
		if (rd_en) begin
			rd_id_q  <= id_mem[rd_idx];
			rd_blk_q <= blk_mem[rd_idx];
			rd_vld_q <= vld_q[rd_idx];
		end
	end

	// Valid bits, all cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (clr_en) begin
				vld_q[clr_idx] <= 1'b0;
			end
		end
	end

	// The one comparator, reused for every entry of a scan.
	always_comb begin
		stat.valid = rd_vld_q;
		stat.hit   = rd_vld_q && (rd_id_q == key);
	end

	assign rd_blk = rd_blk_q;

endmodule

// ===== hdl/fita_free_map.sv =====
// Free map: rows of block-used bits in a memory, row valid bits and a free-bit search.
module fita_free_map import fita_pkg::*; #(
	parameter int BLOCK_COUNT = 512,
	parameter int ROWS        = 16,
	parameter int RW          = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [RW-1:0]     rd_row,
	input  logic              wr_en,
	input  logic [RW-1:0]     wr_row,
	input  logic [WORD_W-1:0] wr_data,
	output map_stat_t         stat,
	output logic [WORD_W-1:0] rd_word
);

	logic [WORD_W-1:0] mem [ROWS];
	logic [ROWS-1:0]   row_vld_q;
	logic [WORD_W-1:0] rd_data_q;
	logic              rd_rv_q;
	logic [RW-1:0]     rd_row_s1;
	logic [WORD_W-1:0] oor_mask;
	logic [WORD_W-1:0] used;

	// Row memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_row];
			rd_rv_q   <= row_vld_q[rd_row];
			rd_row_s1 <= rd_row;
		end
	end

	// A row never written since reset reads as all free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (wr_en) begin
			row_vld_q[wr_row] <= 1'b1;
		end
	end

	// Bits past the last block count as used so that they are never handed out.
	always_comb begin
		for (int k = 0; k < WORD_W; k++) begin
			oor_mask[k] = ((int'(rd_row_s1) * WORD_W + k) >= BLOCK_COUNT);
		end
		used = (rd_rv_q ? rd_data_q : '0) | oor_mask;
	end

	// Lowest clear bit of the row.
	always_comb begin
		stat.free_any = 1'b0;
		stat.free_bit = '0;
		for (int k = WORD_W - 1; k >= 0; k--) begin
			if (!used[k]) begin
				stat.free_any = 1'b1;
				stat.free_bit = WORD_IDX_W'(k);
			end
		end
	end

	assign rd_word = used;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the inode table allocator: directed and random file actions.
`timescale 1ns / 100ps

module testbench import fita_pkg::*; ();

	localparam int FILES       = 16;
	localparam int BLOCKS      = 512;
	localparam int ID_POOL     = 24;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_ITEMS = 210;

	typedef struct {
		status_t    status;
		logic [8:0] blk;
	} reply_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               start        = 1'b0;
	logic [1:0]         action       = ACT_LOOKUP;
	logic signed [31:0] file_id      = '0;
	logic               cfg_valid    = 1'b0;
	logic [8:0]         cfg_data     = '0;
	logic               busy;
	logic               done;
	logic [2:0]         status;
	logic [8:0]         block_number;
	logic               cfg_ready;

	// Shadow copy of the inode table, the free map and the reserved bound.
	logic        inode_valid [FILES];
	logic [31:0] inode_id    [FILES];
	logic [8:0]  inode_blk   [FILES];
	logic        blk_taken   [BLOCKS];
	logic [8:0]  reserved_top;

	reply_t      replies_due [$];
	logic [31:0] id_pool     [ID_POOL];
	int          mismatches  = 0;
	int          burst_left  = 0;
	int          gap_limit   = 0;

	file_inode_table_allocator #(
		.MAX_FILES   (FILES),
		.BLOCK_COUNT (BLOCKS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.file_id      (file_id),
		.done         (done),
		.status       (status),
		.block_number (block_number),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Returns the slot of the live file with this id, or -1 when there is none.
	function automatic int find_file(logic [31:0] id);
		int i;
		for (i = 0; i < FILES; i++) begin
			if (inode_valid[i] && inode_id[i] == id)
				return i;
		end
		return -1;
	endfunction

	// Applies one action to the shadow state and returns the reply it should give.
	function automatic reply_t apply_action(action_t act, logic [31:0] id);
		reply_t r;
		int     hit;
		int     slot;
		int     free_blk;
		int     i;
		r.status = ST_OK;
		r.blk    = '0;
		hit      = find_file(id);
		slot     = -1;
		free_blk = -1;
		case (act)
			ACT_LOOKUP: begin
				if (hit >= 0)
					r.blk = inode_blk[hit];
				else
					r.status = ST_NOT_FOUND;
			end
			ACT_CREATE: begin
				for (i = FILES - 1; i >= 0; i--) begin
					if (!inode_valid[i])
						slot = i;
				end
				for (i = BLOCKS - 1; i >= 0; i--) begin
					if (!blk_taken[i])
						free_blk = i;
				end
				// The slot check comes before the free map search, so no block leaks.
				if (hit >= 0)
					r.status = ST_EXISTS;
				else if (slot < 0)
					r.status = ST_FULL;
				else if (free_blk < 0)
					r.status = ST_NO_BLOCK;
				else begin
					blk_taken[free_blk] = 1'b1;
					inode_valid[slot]   = 1'b1;
					inode_id[slot]      = id;
					inode_blk[slot]     = free_blk[8:0];
					r.blk               = free_blk[8:0];
				end
			end
			ACT_DELETE: begin
				if (hit >= 0) begin
					inode_valid[hit]          = 1'b0;
					blk_taken[inode_blk[hit]] = 1'b0;
				end else
					r.status = ST_NOT_FOUND;
			end
			default: begin
				// Format rewrites the free map only; the table stays as it is.
				for (i = 0; i < BLOCKS; i++)
					blk_taken[i] = (i <= reserved_top);
			end
		endcase
		return r;
	endfunction

	// Prints one line per mismatch and counts it.
	task automatic flag_mismatch(string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// Sends one action beat, records its reply and idles between bursts.
	task automatic send_item(action_t act, logic [31:0] id);
		start   <= 1'b1;
		action  <= act;
		file_id <= id;
		do @(negedge clk); while (busy);
		@(posedge clk);
		replies_due.push_back(apply_action(act, id));
		if (gap_limit > 0) begin
			if (burst_left == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, gap_limit)) @(posedge clk);
				burst_left = $urandom_range(1, 10);
			end else
				burst_left--;
		end
	endtask

	// Writes the reserved bound once the block has gone idle.
	task automatic set_reserved(logic [8:0] value);
		start <= 1'b0;
		do @(negedge clk); while (replies_due.size() != 0 || busy);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid    <= 1'b0;
		reserved_top  = value;
	endtask

	// Picks an id from the small pool most of the time so that actions hit live files.
	function automatic logic [31:0] pick_id();
		if ($urandom_range(0, 99) < 82)
			return id_pool[$urandom_range(0, ID_POOL - 1)];
		return $urandom;
	endfunction

	// Lookups and deletes that miss, create, an existing id, then a format.
	task automatic test_basic_ops();
		set_reserved(LAST_RES_RST);
		send_item(ACT_LOOKUP, 32'h0000_0000);
		send_item(ACT_DELETE, 32'h7FFF_FFFF);
		send_item(ACT_CREATE, 32'h8000_0000);
		send_item(ACT_CREATE, 32'h7FFF_FFFF);
		send_item(ACT_CREATE, 32'h8000_0000);
		send_item(ACT_LOOKUP, 32'h7FFF_FFFF);
		send_item(ACT_DELETE, 32'h8000_0000);
		send_item(ACT_LOOKUP, 32'h8000_0000);
		send_item(ACT_FORMAT, 32'hFFFF_FFFF);
	endtask

	// Fills every slot, then a create on a full table and one for an existing id.
	task automatic test_table_full();
		int i;
		for (i = 0; i < FILES - 1; i++)
			send_item(ACT_CREATE, 32'h0000_1000 + i);
		send_item(ACT_CREATE, 32'h5A5A_5A5A);
		send_item(ACT_CREATE, 32'h7FFF_FFFF);
	endtask

	// Reserved bound at both extremes: a full free map, then an almost empty one.
	task automatic test_free_map_full();
		set_reserved(9'd511);
		send_item(ACT_DELETE, 32'h0000_1000);
		send_item(ACT_FORMAT, 32'h0000_0000);
		send_item(ACT_CREATE, 32'h5A5A_5A5A);
		send_item(ACT_LOOKUP, 32'h0000_1001);
		set_reserved(9'd0);
		send_item(ACT_FORMAT, 32'h1234_5678);
		send_item(ACT_CREATE, 32'h5A5A_5A5A);
	endtask

	// Random traffic in phases, each with its own reserved bound and idling pattern.
	task automatic test_random_traffic();
		logic [8:0] bounds [8];
		int         gaps   [8];
		int         p;
		int         n;
		int         pick;
		bounds = '{9'd0, 9'd511, 9'd1, 9'd500, 9'd508, 9'd0, 9'd255, 9'd0};
		gaps   = '{0, 6, 40, 3, 0, 12, 25, 5};
		bounds[5] = $urandom_range(0, 511);
		bounds[7] = $urandom_range(490, 511);
		for (n = 0; n < ID_POOL; n++)
			id_pool[n] = $urandom;
		id_pool[0] = 32'h0000_0000;
		id_pool[1] = 32'hFFFF_FFFF;
		id_pool[2] = 32'h8000_0000;
		id_pool[3] = 32'h7FFF_FFFF;
		for (p = 0; p < 8; p++) begin
			set_reserved(bounds[p]);
			gap_limit  = gaps[p];
			burst_left = 0;
			// Part of the pool changes each phase so that fresh ids come and go.
			for (n = 0; n < 6; n++)
				id_pool[$urandom_range(4, ID_POOL - 1)] = $urandom;
			send_item(ACT_FORMAT, $urandom);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 30)
					send_item(ACT_LOOKUP, pick_id());
				else if (pick < 65)
					send_item(ACT_CREATE, pick_id());
				else if (pick < 93)
					send_item(ACT_DELETE, pick_id());
				else
					send_item(ACT_FORMAT, $urandom);
			end
		end
		gap_limit = 0;
	endtask

	// Each reply is checked against the oldest outstanding one, field by field.
	always @(negedge clk) begin : reply_check
		reply_t due;
		if (arst_n && done) begin
			if (replies_due.size() == 0)
				flag_mismatch($sformatf("unexpected reply: status %0d block %0d",
					status, block_number));
			else begin
				due = replies_due.pop_front();
				if (status !== due.status)
					flag_mismatch($sformatf("status %0d, wanted %s",
						status, due.status.name()));
				if (block_number !== due.blk)
					flag_mismatch($sformatf("block_number %0d, wanted %0d",
						block_number, due.blk));
			end
		end
	end

	// The run is stopped when no beat of any kind moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Shadow state after reset, then the tests in turn.
	initial begin : run_tests
		int i;
		for (i = 0; i < FILES; i++) begin
			inode_valid[i] = 1'b0;
			inode_id[i]    = '0;
			inode_blk[i]   = '0;
		end
		for (i = 0; i < BLOCKS; i++)
			blk_taken[i] = 1'b0;
		reserved_top = LAST_RES_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_table_full();
		test_free_map_full();
		test_random_traffic();
		start <= 1'b0;
		do @(negedge clk); while (replies_due.size() != 0);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && replies_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
